// ----- hdl/hebp_pkg.sv -----
`default_nettype none

package hebp_pkg;

    // s_tuser operation codes
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    // bits per output word
    localparam int BYTE_BITS = 8;

    // output word fields as they sit in m_tdata
    typedef struct packed {
        logic [3:0] nbits;
        logic [7:0] data;
    } out_word_t;

endpackage

`default_nettype wire

// ----- hdl/hebp_code_table.sv -----
`default_nettype none

// Code table: one write port, one registered read port.
// Per-entry valid bits cleared at reset; an unwritten entry reads as empty.
module hebp_code_table #(
    parameter int DEPTH  = 256,
    parameter int SYM_W  = 8,
    parameter int CODE_W = 32,
    parameter int LEN_W  = 6
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              wr_en,
    input  wire logic [SYM_W-1:0]  wr_addr,
    input  wire logic [CODE_W-1:0] wr_code,
    input  wire logic [LEN_W-1:0]  wr_len,
    input  wire logic              rd_en,
    input  wire logic [SYM_W-1:0]  rd_addr,
    output logic      [CODE_W-1:0] rd_code,
    output logic      [LEN_W-1:0]  rd_len
);

    logic [CODE_W+LEN_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]        valid_reg;
    logic [CODE_W+LEN_W-1:0] rd_entry_reg;
    logic                    rd_hit_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_len, wr_code};
        end
        if (rd_en) begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_code = rd_hit_reg ? rd_entry_reg[CODE_W-1:0] : '0;
    assign rd_len  = rd_hit_reg ? rd_entry_reg[CODE_W+LEN_W-1:CODE_W] : '0;

endmodule

`default_nettype wire

// ----- hdl/huffman_encoder_bit_packer.sv -----
// Static Huffman encoder with bit packer.
// Input stream (s_*): s_tuser carries the op: load a table entry, encode a
// byte, or flush the partial byte. s_tdata carries symbol, code word and
// code length. Output stream (m_*): one packed byte per word, earliest bit
// in the MSB, with its count of meaningful bits; m_tlast marks the final
// word caused by one input word.
// A load writes its table entry. An encode that yields n output words is accepted,
// reads the table, then sends one word per cycle out of the shared byte-select
// shifter while the output slot is free; an encode whose bits all stay pending,
// or with an empty code, sends no word. At the default code length n is at most
// 4. A flush with nothing pending sends no word. s_tready is high only while the
// sequencer is idle, so one input word is in work at a time; the output register
// lets the next input word be taken while the last result still waits. When
// m_tready is low while a word waits, the sequencer holds in its emit or flush
// step and the output word stays put. Reset (aresetn low, synchronous) empties the
// bit buffer, drops any pending output and marks every table entry empty at once.
`default_nettype none

module huffman_encoder_bit_packer #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,  // symbol[7:0], code_word[39:8], code_length[45:40]
    input  wire logic [1:0]  s_tuser,  // op[1:0]
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,  // packed_byte[7:0], valid_bits[11:8]
    output logic             m_tlast   // last
);

    localparam int SYM_W  = $clog2(SYMBOL_COUNT);
    localparam int CODE_W = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
    localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1);
    localparam int ACC_W  = MAX_CODE_LEN + 7;   // code plus up to 7 pending bits
    localparam int TOT_W  = $clog2(ACC_W + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOKUP = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;
    localparam logic [1:0] ST_FLUSH  = 2'd3;

    // input fields
    logic [1:0]  in_op;
    logic [7:0]  in_sym;
    logic [31:0] in_word;
    logic [5:0]  in_len;

    assign in_op   = s_tuser;
    assign in_sym  = s_tdata[7:0];
    assign in_word = s_tdata[39:8];
    assign in_len  = s_tdata[45:40];

    logic [1:0]       state_reg, state_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [TOT_W-1:0] total_reg, total_next;
    logic [6:0]       pend_bits_reg, pend_bits_next;
    logic [2:0]       pend_cnt_reg, pend_cnt_next;
    logic             out_valid_reg, out_valid_next;
    hebp_pkg::out_word_t out_word_reg, out_word_next;
    logic             out_last_reg, out_last_next;

    logic accept;
    logic sym_ok;
    logic slot_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign sym_ok    = ({1'b0, in_sym} < 9'(SYMBOL_COUNT));
    assign slot_free = !out_valid_reg || m_tready;

    // load path: clamp length, drop code bits above it
    logic [5:0]  len_clamp;
    logic [31:0] word_masked;

    assign len_clamp   = (in_len > 6'(MAX_CODE_LEN)) ? 6'(MAX_CODE_LEN) : in_len;
    assign word_masked = in_word & ~(32'hFFFF_FFFF << len_clamp);

    logic              tbl_wr_en;
    logic              tbl_rd_en;
    logic [CODE_W-1:0] tbl_code;
    logic [LEN_W-1:0]  tbl_len;

    assign tbl_wr_en = accept && (in_op == hebp_pkg::OP_LOAD) && sym_ok;
    assign tbl_rd_en = accept && (in_op == hebp_pkg::OP_ENCODE) && sym_ok;

    hebp_code_table #(
        .DEPTH  (SYMBOL_COUNT),
        .SYM_W  (SYM_W),
        .CODE_W (CODE_W),
        .LEN_W  (LEN_W)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (tbl_wr_en),
        .wr_addr (in_sym[SYM_W-1:0]),
        .wr_code (word_masked[CODE_W-1:0]),
        .wr_len  (len_clamp[LEN_W-1:0]),
        .rd_en   (tbl_rd_en),
        .rd_addr (in_sym[SYM_W-1:0]),
        .rd_code (tbl_code),
        .rd_len  (tbl_len)
    );

    // shared byte selector: top 8 of the remaining bits
    logic [TOT_W-1:0] shift_amt;
    logic [7:0]       sel_byte;
    logic [2:0]       rem_cnt;
    logic [6:0]       rem_bits;

    assign shift_amt = total_reg - TOT_W'(hebp_pkg::BYTE_BITS);
    assign sel_byte  = 8'(acc_reg >> shift_amt);
    // bits left once the current byte is out (or all of them if under a byte)
    assign rem_cnt   = (total_reg < TOT_W'(hebp_pkg::BYTE_BITS)) ? 3'(total_reg)
                                                                  : 3'(shift_amt);
    assign rem_bits  = 7'(acc_reg) & ~(7'h7F << rem_cnt);

    always_comb begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        total_next     = total_reg;
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (in_op)
                        hebp_pkg::OP_ENCODE: begin
                            if (sym_ok) begin
                                state_next = ST_LOOKUP;
                            end
                        end
                        hebp_pkg::OP_FLUSH: begin
                            if (pend_cnt_reg != 3'd0) begin
                                state_next = ST_FLUSH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOOKUP: begin
                if (tbl_len == '0) begin
                    state_next = ST_IDLE;   // empty code appends nothing
                end else begin
                    acc_next   = (ACC_W'(pend_bits_reg) << tbl_len) | ACC_W'(tbl_code);
                    total_next = TOT_W'(pend_cnt_reg) + TOT_W'(tbl_len);
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (total_reg < TOT_W'(hebp_pkg::BYTE_BITS)) begin
                    // too few bits for a byte: keep them pending
                    pend_bits_next = rem_bits;
                    pend_cnt_next  = rem_cnt;
                    state_next     = ST_IDLE;
                end else if (slot_free) begin
                    out_valid_next      = 1'b1;
                    out_word_next.data  = sel_byte;
                    out_word_next.nbits = 4'(hebp_pkg::BYTE_BITS);
                    out_last_next       = (shift_amt < TOT_W'(hebp_pkg::BYTE_BITS));
                    total_next          = shift_amt;
                    if (shift_amt < TOT_W'(hebp_pkg::BYTE_BITS)) begin
                        pend_bits_next = rem_bits;
                        pend_cnt_next  = rem_cnt;
                        state_next     = ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                if (slot_free) begin
                    out_valid_next      = 1'b1;
                    out_word_next.data  = 8'(pend_bits_reg) <<
                                          (4'(hebp_pkg::BYTE_BITS) - {1'b0, pend_cnt_reg});
                    out_word_next.nbits = {1'b0, pend_cnt_reg};
                    out_last_next       = 1'b1;
                    pend_bits_next      = '0;
                    pend_cnt_next       = '0;
                    state_next          = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        acc_reg      <= acc_next;
        total_reg    <= total_next;
        out_word_reg <= out_word_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_word_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ----- hdl/hebp_checker.sv -----
`default_nettype none

module hebp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tlast
);

    // output word held while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed under stall");

    // bit count within 1..8, pad bits zero
    a_nbits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[11:8] != 4'd0)
                  && (m_tdata[11:8] <= 4'(hebp_pkg::BYTE_BITS))
                  && (m_tdata[15:12] == 4'd0))
        else $error("bad valid_bits or pad");

    // partial byte comes only from a flush, always last
    a_partial_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[11:8] != 4'(hebp_pkg::BYTE_BITS)) |-> m_tlast)
        else $error("partial byte not marked last");

    // reset drops any pending output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind huffman_encoder_bit_packer hebp_checker u_hebp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
